@@ rtl/core/blp_pkg.sv @@
// ----------------------------------------------------------------------------
// blp_pkg
// Types and constants shared by the battery level policy block.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONSERVE_ENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSERVE_EXIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_EXIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_CONF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_CONF  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CKPT_ENABLE    = 3'd6;

  // policy levels
  localparam logic [1:0] LVL_NORMAL   = 2'd0;
  localparam logic [1:0] LVL_CONSERVE = 2'd1;
  localparam logic [1:0] LVL_PROTECT  = 2'd2;
  localparam logic [1:0] LVL_UNUSED   = 2'd3;

  // checkpoint phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FLIGHT = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_FAILED = 2'd3;

  localparam logic [0:0] KIND_SAMPLE = 1'b0;
  localparam logic [0:0] KIND_REPORT = 1'b1;

  localparam logic [7:0] PCT_MAX = 8'd100;
  localparam logic [7:0] RUN_MAX = 8'd255;

  localparam logic [6:0] CAP_PROTECT  = 7'd35;
  localparam logic [6:0] CAP_CONSERVE = 7'd65;
  localparam logic [6:0] CAP_NORMAL   = 7'd100;

  localparam logic [6:0] RST_CONSERVE_ENTER = 7'd25;
  localparam logic [6:0] RST_CONSERVE_EXIT  = 7'd30;
  localparam logic [6:0] RST_PROTECT_ENTER  = 7'd12;
  localparam logic [6:0] RST_PROTECT_EXIT   = 7'd16;
  localparam logic [7:0] RST_PROTECT_CONF   = 8'd3;
  localparam logic [7:0] RST_RECOVERY_CONF  = 8'd2;

  typedef struct packed {
    logic       kind;
    logic       available;
    logic       charging;
    logic [7:0] charge_pct;
    logic       checkpoint_ok;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] policy_level;
    logic       optional_work_ok;
    logic       high_power_ok;
    logic [6:0] backlight_cap;
    logic       checkpoint_start;
    logic [1:0] checkpoint_phase;
  } out_item_t;

  typedef struct packed {
    logic [6:0] conserve_enter_pct;
    logic [6:0] conserve_exit_pct;
    logic [6:0] protect_enter_pct;
    logic [6:0] protect_exit_pct;
    logic [7:0] protect_confirm_count;
    logic [7:0] recovery_confirm_count;
    logic       checkpoint_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0] level;
    logic [7:0] low_run;
    logic [7:0] recover_run;
    logic [1:0] phase;
  } state_t;

  function automatic logic [7:0] sat_bump(input logic [7:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 8'd1;
  endfunction

endpackage

@@ rtl/core/blp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// blp_cfg_regs
// Threshold, count and checkpoint enable registers, written by index.
// ----------------------------------------------------------------------------
module blp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [blp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [blp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output blp_pkg::cfg_t                  cfg
);

  blp_pkg::cfg_t cfg_r;
  blp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        blp_pkg::CFG_CONSERVE_ENTER: cfg_nxt.conserve_enter_pct     = cfg_wdata[6:0];
        blp_pkg::CFG_CONSERVE_EXIT:  cfg_nxt.conserve_exit_pct      = cfg_wdata[6:0];
        blp_pkg::CFG_PROTECT_ENTER:  cfg_nxt.protect_enter_pct      = cfg_wdata[6:0];
        blp_pkg::CFG_PROTECT_EXIT:   cfg_nxt.protect_exit_pct       = cfg_wdata[6:0];
        blp_pkg::CFG_PROTECT_CONF:   cfg_nxt.protect_confirm_count  = cfg_wdata;
        blp_pkg::CFG_RECOVERY_CONF:  cfg_nxt.recovery_confirm_count = cfg_wdata;
        blp_pkg::CFG_CKPT_ENABLE:    cfg_nxt.checkpoint_enable      = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conserve_enter_pct     <= blp_pkg::RST_CONSERVE_ENTER;
      cfg_r.conserve_exit_pct      <= blp_pkg::RST_CONSERVE_EXIT;
      cfg_r.protect_enter_pct      <= blp_pkg::RST_PROTECT_ENTER;
      cfg_r.protect_exit_pct       <= blp_pkg::RST_PROTECT_EXIT;
      cfg_r.protect_confirm_count  <= blp_pkg::RST_PROTECT_CONF;
      cfg_r.recovery_confirm_count <= blp_pkg::RST_RECOVERY_CONF;
      cfg_r.checkpoint_enable      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/blp_policy.sv @@
// ----------------------------------------------------------------------------
// blp_policy
// Next policy state and result item for one input item.
// ----------------------------------------------------------------------------
module blp_policy (
  input  blp_pkg::cfg_t     cfg,
  input  blp_pkg::state_t   cur,
  input  blp_pkg::in_item_t item,
  output blp_pkg::state_t   nxt,
  output blp_pkg::out_item_t res
);

  logic [1:0] prev;
  logic [7:0] pct;
  logic [7:0] low_b;
  logic [7:0] rec_b;
  logic       accepted;
  logic       start;
  logic       prot;

  always_comb begin
    pct      = item.charge_pct;
    prev     = cur.level[1] ? blp_pkg::LVL_PROTECT : cur.level;
    low_b    = blp_pkg::sat_bump(cur.low_run);
    rec_b    = blp_pkg::sat_bump(cur.recover_run);
    nxt      = cur;
    accepted = 1'b1;
    start    = 1'b0;

    if (item.kind == blp_pkg::KIND_REPORT) begin
      if (cur.phase == blp_pkg::PH_FLIGHT) begin
        nxt.phase = item.checkpoint_ok ? blp_pkg::PH_DONE : blp_pkg::PH_FAILED;
      end
    end else if (item.available && pct > blp_pkg::PCT_MAX) begin
      // out-of-range sample: reject, nothing moves
      accepted = 1'b0;
    end else begin
      if (item.charging) begin
        nxt.low_run     = '0;
        nxt.recover_run = '0;
        nxt.level       = blp_pkg::LVL_NORMAL;
      end else if (!item.available) begin
        nxt.low_run     = '0;
        nxt.recover_run = '0;
        nxt.level       = (prev == blp_pkg::LVL_PROTECT) ? blp_pkg::LVL_PROTECT
                                                         : blp_pkg::LVL_NORMAL;
      end else begin
        nxt.low_run = (pct <= {1'b0, cfg.protect_enter_pct}) ? low_b : '0;
        if (prev == blp_pkg::LVL_PROTECT) begin
          if (pct < {1'b0, cfg.protect_exit_pct}) begin
            nxt.recover_run = '0;
            nxt.level       = blp_pkg::LVL_PROTECT;
          end else begin
            nxt.recover_run = rec_b;
            nxt.level       = (rec_b >= cfg.recovery_confirm_count) ?
                              blp_pkg::LVL_CONSERVE : blp_pkg::LVL_PROTECT;
          end
        end else begin
          nxt.recover_run = '0;
          if (nxt.low_run >= cfg.protect_confirm_count) begin
            nxt.level = blp_pkg::LVL_PROTECT;
          end else if (prev == blp_pkg::LVL_CONSERVE) begin
            nxt.level = (pct < {1'b0, cfg.conserve_exit_pct}) ?
                        blp_pkg::LVL_CONSERVE : blp_pkg::LVL_NORMAL;
          end else begin
            nxt.level = (pct <= {1'b0, cfg.conserve_enter_pct}) ?
                        blp_pkg::LVL_CONSERVE : blp_pkg::LVL_NORMAL;
          end
        end
      end

      // entering or leaving protect returns the checkpoint phase to idle
      if (prev != nxt.level &&
          (prev == blp_pkg::LVL_PROTECT || nxt.level == blp_pkg::LVL_PROTECT)) begin
        nxt.phase = blp_pkg::PH_IDLE;
      end
      if (prev != blp_pkg::LVL_PROTECT && nxt.level == blp_pkg::LVL_PROTECT &&
          cfg.checkpoint_enable && nxt.phase == blp_pkg::PH_IDLE) begin
        nxt.phase = blp_pkg::PH_FLIGHT;
        start     = 1'b1;
      end
    end

    prot                 = nxt.level[1];
    res.accepted         = accepted;
    res.policy_level     = nxt.level;
    res.optional_work_ok = !prot;
    res.high_power_ok    = (nxt.level == blp_pkg::LVL_NORMAL);
    res.backlight_cap    = prot ? blp_pkg::CAP_PROTECT :
                           (nxt.level == blp_pkg::LVL_CONSERVE) ? blp_pkg::CAP_CONSERVE
                                                                : blp_pkg::CAP_NORMAL;
    res.checkpoint_start = start;
    res.checkpoint_phase = nxt.phase;
  end

endmodule

@@ rtl/core/battery_level_policy_hysteresis.sv @@
// ----------------------------------------------------------------------------
// battery_level_policy_hysteresis
// Three-level battery policy with hysteresis, confirm counts and checkpoint.
// ----------------------------------------------------------------------------
// Result path: an accepted item is held in the input register, then its result
//   in the result register; a stalled output holds the item in the input stage.
// Throughput: one item per cycle while out_stall is low; the next state is computed from the state register.
// Reset: synchronous active-low rst_n; level normal, counters zero, phase
//   idle, registers at their defaults, both stages empty.
// ----------------------------------------------------------------------------
module battery_level_policy_hysteresis (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  blp_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output blp_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [blp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [blp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  blp_pkg::cfg_t      cfg;
  blp_pkg::state_t    st_r;
  blp_pkg::state_t    st_nxt;
  blp_pkg::in_item_t  in_data_r;
  blp_pkg::out_item_t res;
  blp_pkg::out_item_t out_data_r;
  logic               in_v_r;
  logic               out_v_r;
  logic               move;

  blp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blp_policy u_policy (
    .cfg  (cfg),
    .cur  (st_r),
    .item (in_data_r),
    .nxt  (st_nxt),
    .res  (res)
  );

  // item leaves the input stage when the result register frees up
  assign move     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (move) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.level != blp_pkg::LVL_UNUSED)
    else $error("policy level register holds unused code");

  a_state_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(st_r) |-> $past(move))
    else $error("policy state changed without an item transfer");

  a_start_in_protect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.checkpoint_start |->
      out_data.policy_level == blp_pkg::LVL_PROTECT &&
      out_data.checkpoint_phase == blp_pkg::PH_FLIGHT && out_data.accepted)
    else $error("checkpoint start outside protect entry");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    move && !res.accepted |=> $stable(st_r))
    else $error("rejected sample changed policy state");

endmodule
